// File: hw/rtl/brute_force_nearest_point_defines.svh
// Assertion macros shared by the nearest-point search RTL.
// Included by files that carry concurrent checks; depends on nothing else.
`ifndef BRUTE_FORCE_NEAREST_POINT_DEFINES_SVH
`define BRUTE_FORCE_NEAREST_POINT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BFNP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("bfnp: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define BFNP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("bfnp: next-cycle check failed");

`endif

// File: hw/rtl/bfnp_pkg.sv
// Shared types and constants of the nearest-point search block.
// Used by bfnp_dist and brute_force_nearest_point; depends on nothing.
package bfnp_pkg;

  localparam int COORD_W        = 16;
  localparam int INDEX_W        = 10;
  localparam int COUNT_W        = 11;
  localparam int DIST_W         = 34;
  localparam int SQ_W           = 2 * COORD_W;
  localparam int DEF_MAX_POINTS = 1024;

  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 96;

  localparam logic FUNC_STORE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic signed [COORD_W-1:0] z;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } point_t;

  // Status of the distance pipeline as seen by the sequencer.
  typedef struct packed {
    logic valid;  // a finished distance is on the outputs
    logic busy;   // inner stages still hold points
  } dist_stat_t;

endpackage

// File: hw/rtl/bfnp_dist.sv
// Pipelined squared-distance unit: absolute differences, squares, sum.
// Depends on bfnp_pkg for point_t, dist_stat_t and field widths.
module bfnp_dist #(
  parameter int IDX_W = 10
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [IDX_W-1:0]            in_idx,
  input  bfnp_pkg::point_t            in_pt,
  input  bfnp_pkg::point_t            query,
  output bfnp_pkg::dist_stat_t        stat,
  output logic [IDX_W-1:0]            out_idx,
  output bfnp_pkg::point_t            out_pt,
  output logic [bfnp_pkg::DIST_W-1:0] out_dist
);

  localparam int CW = bfnp_pkg::COORD_W;

  logic                         s2_v_r, s3_v_r, s4_v_r;
  logic [IDX_W-1:0]             s2_idx_r, s3_idx_r, s4_idx_r;
  bfnp_pkg::point_t             s2_pt_r, s3_pt_r, s4_pt_r;
  logic [CW-1:0]                ad_x_nxt, ad_y_nxt, ad_z_nxt;
  logic [CW-1:0]                ad_x_r, ad_y_r, ad_z_r;
  logic [bfnp_pkg::SQ_W-1:0]    sq_x_r, sq_y_r, sq_z_r;
  logic [bfnp_pkg::DIST_W-1:0]  sum_r;

  function automatic logic [CW-1:0] abs_diff(logic signed [CW-1:0] a,
                                             logic signed [CW-1:0] b);
    logic signed [CW:0] d;
    d = {a[CW-1], a} - {b[CW-1], b};
    return d[CW] ? CW'(-d) : CW'(d);
  endfunction

  always_comb begin
    ad_x_nxt = abs_diff(in_pt.x, query.x);
    ad_y_nxt = abs_diff(in_pt.y, query.y);
    ad_z_nxt = abs_diff(in_pt.z, query.z);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      s2_v_r <= in_valid;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_idx_r <= in_idx;
    s2_pt_r  <= in_pt;
    ad_x_r   <= ad_x_nxt;
    ad_y_r   <= ad_y_nxt;
    ad_z_r   <= ad_z_nxt;
    s3_idx_r <= s2_idx_r;
    s3_pt_r  <= s2_pt_r;
    sq_x_r   <= bfnp_pkg::SQ_W'(ad_x_r) * bfnp_pkg::SQ_W'(ad_x_r);
    sq_y_r   <= bfnp_pkg::SQ_W'(ad_y_r) * bfnp_pkg::SQ_W'(ad_y_r);
    sq_z_r   <= bfnp_pkg::SQ_W'(ad_z_r) * bfnp_pkg::SQ_W'(ad_z_r);
    s4_idx_r <= s3_idx_r;
    s4_pt_r  <= s3_pt_r;
    // Three squares of 16-bit magnitudes always fit in 34 bits.
    sum_r    <= bfnp_pkg::DIST_W'(sq_x_r) + bfnp_pkg::DIST_W'(sq_y_r)
              + bfnp_pkg::DIST_W'(sq_z_r);
  end

  assign stat.valid = s4_v_r;
  assign stat.busy  = s2_v_r | s3_v_r;
  assign out_idx    = s4_idx_r;
  assign out_pt     = s4_pt_r;
  assign out_dist   = sum_r;

endmodule

// File: hw/rtl/brute_force_nearest_point.sv
// Brute-force nearest-point search over a store of 3D reference points.
// Top level: point memory, scan sequencer, running minimum and output register.
// Depends on bfnp_pkg, bfnp_dist and brute_force_nearest_point_defines.svh.
//
// Usage:
//   The input stream carries one request per transfer. in_tuser selects the
//   kind: a store request writes the point into slot point_index and gives
//   no result; a query request searches slots 0 .. reference_count-1 and
//   gives exactly one result on the output stream.
//   reference_count is written through cfg_wr_en / cfg_wr_data while the
//   block is idle; a value above MAX_POINTS searches all MAX_POINTS slots.
//   Stores can be taken back to back. A query searches its slots through
//   the single memory read port feeding one distance pipeline at one point
//   per cycle, so its time grows with the number of searched slots.
//   in_tready is low while a query is in progress.
//   Ties go to the lowest slot. With nothing to search the result has
//   found (out_tuser) low and all data fields zero.
//   A finished result waits in the output register while the receiver holds
//   out_tready low; new requests are still taken then, and a later query
//   holds its own result back until the register is free.
//   Reset clears the sequencer and reference_count; point memory is not
//   cleared, so slots must be stored before they are searched.
`include "brute_force_nearest_point_defines.svh"

module brute_force_nearest_point #(
  parameter int MAX_POINTS = bfnp_pkg::DEF_MAX_POINTS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Fields from bit 0: point_index[9:0], coord_x[25:10], coord_y[41:26],
  // coord_z[57:42], zero fill[63:58].
  input  logic [bfnp_pkg::IN_TDATA_W-1:0]  in_tdata,
  // Fields from bit 0: func.
  input  logic                             in_tuser,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // Fields from bit 0: nearest_index[9:0], nearest_x[25:10],
  // nearest_y[41:26], nearest_z[57:42], squared_distance[91:58],
  // zero fill[95:92].
  output logic [bfnp_pkg::OUT_TDATA_W-1:0] out_tdata,
  // Fields from bit 0: found.
  output logic                             out_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic                             cfg_wr_en,
  input  logic [bfnp_pkg::COUNT_W-1:0]     cfg_wr_data
);

  localparam int AW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW    = $clog2(MAX_POINTS + 1);
  localparam int CMP_W = (CW > bfnp_pkg::COUNT_W) ? CW : bfnp_pkg::COUNT_W;
  localparam int IW    = bfnp_pkg::INDEX_W;
  localparam int DW    = bfnp_pkg::DIST_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  state_t                     state_r;
  logic [bfnp_pkg::COUNT_W-1:0] cfg_count_r;

  // Request decode.
  logic                       in_acc;
  logic [IW-1:0]              in_idx;
  bfnp_pkg::point_t           in_pt;
  logic [CMP_W-1:0]           in_idx_ext;
  logic                       mem_we;
  logic [CMP_W-1:0]           cfg_ext;
  logic [CW-1:0]              eff_count;

  // Point memory and read stage.
  bfnp_pkg::point_t           mem [MAX_POINTS];
  bfnp_pkg::point_t           mem_q_r;
  logic                       rd_en;
  logic                       rd_v_r;
  logic [AW-1:0]              rd_idx_r;

  // Query and scan control.
  bfnp_pkg::point_t           query_r;
  logic [CW-1:0]              cnt_r;
  logic [CW-1:0]              scan_cnt_r;
  logic [CW-1:0]              scan_cnt_nxt;

  // Running minimum.
  logic                       have_r;
  logic [DW-1:0]              best_d_r;
  logic [AW-1:0]              best_idx_r;
  bfnp_pkg::point_t           best_pt_r;
  logic                       take;

  // Distance pipeline.
  bfnp_pkg::dist_stat_t       dist_stat;
  logic [AW-1:0]              dist_idx;
  bfnp_pkg::point_t           dist_pt;
  logic [DW-1:0]              dist_val;
  logic                       pipe_busy;

  // Output register.
  logic                       out_valid_r;
  logic                       out_found_r;
  logic [IW-1:0]              out_idx_r;
  bfnp_pkg::point_t           out_pt_r;
  logic [DW-1:0]              out_dist_r;
  logic                       out_free;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_idx    = in_tdata[IW-1:0];
  assign in_pt.x   = in_tdata[IW +: bfnp_pkg::COORD_W];
  assign in_pt.y   = in_tdata[IW + bfnp_pkg::COORD_W +: bfnp_pkg::COORD_W];
  assign in_pt.z   = in_tdata[IW + 2*bfnp_pkg::COORD_W +: bfnp_pkg::COORD_W];

  // Stores to slots beyond the memory are dropped.
  assign in_idx_ext = CMP_W'(in_idx);
  assign mem_we     = in_acc && (in_tuser == bfnp_pkg::FUNC_STORE)
                      && (in_idx_ext < CMP_W'(MAX_POINTS));

  // A count above the memory depth searches the whole memory.
  assign cfg_ext   = CMP_W'(cfg_count_r);
  assign eff_count = (cfg_ext > CMP_W'(MAX_POINTS)) ? CW'(MAX_POINTS) : CW'(cfg_ext);

  assign rd_en        = (state_r == ST_SCAN);
  assign scan_cnt_nxt = scan_cnt_r + CW'(1);
  assign pipe_busy    = rd_v_r || dist_stat.busy || dist_stat.valid;
  assign take         = dist_stat.valid && (!have_r || (dist_val < best_d_r));
  assign out_free     = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_count_r <= '0;
    end else if (cfg_wr_en) begin
      cfg_count_r <= cfg_wr_data;
    end
  end

  // Point memory: one write port for stores, one registered read port for scans.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[AW'(in_idx_ext)] <= in_pt;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q_r <= mem[scan_cnt_r[AW-1:0]];
    end
    rd_idx_r <= scan_cnt_r[AW-1:0];
  end

  bfnp_dist #(
    .IDX_W (AW)
  ) u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (rd_v_r),
    .in_idx   (rd_idx_r),
    .in_pt    (mem_q_r),
    .query    (query_r),
    .stat     (dist_stat),
    .out_idx  (dist_idx),
    .out_pt   (dist_pt),
    .out_dist (dist_val)
  );

  // Sequencer, running minimum and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_v_r      <= 1'b0;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
      scan_cnt_r  <= '0;
      cnt_r       <= '0;
    end else begin
      rd_v_r <= rd_en;

      // In the finishing step a taken result is replaced by the new one below.
      if (out_valid_r && out_tready && (state_r != ST_FINISH)) begin
        out_valid_r <= 1'b0;
      end

      if (take) begin
        have_r     <= 1'b1;
        best_d_r   <= dist_val;
        best_idx_r <= dist_idx;
        best_pt_r  <= dist_pt;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_acc && (in_tuser == bfnp_pkg::FUNC_QUERY)) begin
            query_r    <= in_pt;
            cnt_r      <= eff_count;
            scan_cnt_r <= '0;
            have_r     <= 1'b0;
            state_r    <= (eff_count == '0) ? ST_FINISH : ST_SCAN;
          end
        end
        ST_SCAN: begin
          scan_cnt_r <= scan_cnt_nxt;
          if (scan_cnt_nxt == cnt_r) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!pipe_busy) begin
            state_r <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_found_r <= have_r;
            out_idx_r   <= have_r ? IW'(best_idx_r) : '0;
            out_pt_r    <= have_r ? best_pt_r : '0;
            out_dist_r  <= have_r ? best_d_r : '0;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_found_r;
  assign out_tdata  = bfnp_pkg::OUT_TDATA_W'({out_dist_r, out_pt_r.z, out_pt_r.y,
                                              out_pt_r.x, out_idx_r});

  // The distance pipeline is empty whenever new requests are taken.
  `BFNP_ASSERT_IMP(a_idle_pipe_empty, clk, rst_n, state_r == ST_IDLE, !pipe_busy)
  // The scan address never runs past the searched range.
  `BFNP_ASSERT_IMP(a_scan_in_range, clk, rst_n, state_r == ST_SCAN, scan_cnt_r < cnt_r)
  // A result appears only out of the finishing step.
  `BFNP_ASSERT_IMP(a_result_from_finish, clk, rst_n, $rose(out_valid_r),
                   $past(state_r) == ST_FINISH)
  // A finish with a free output register always posts the result.
  `BFNP_ASSERT_NXT(a_finish_posts, clk, rst_n, (state_r == ST_FINISH) && out_free,
                   out_valid_r && (state_r == ST_IDLE))
  // An empty search carries all-zero data.
  `BFNP_ASSERT_IMP(a_empty_zero, clk, rst_n, out_valid_r && !out_found_r, out_tdata == '0)

endmodule
